// ----- hw/rtl/dtt_pkg.sv -----
// shared types and constants for the deadline timeout table
// payload structs, mode and register codes, controller command and status
`timescale 1ns / 1ps
`default_nettype none

package dtt_pkg;

    localparam logic [1:0] MODE_START  = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_PAINT  = 2'd2;
    localparam logic [1:0] MODE_TICK   = 2'd3;

    localparam logic CFG_DEFAULT_TIMEOUT = 1'b0;
    localparam logic CFG_MIN_PAINT_WAIT  = 1'b1;

    localparam logic [31:0] DEFAULT_TIMEOUT_RST = 32'd5000;
    localparam logic [31:0] MIN_PAINT_WAIT_RST  = 32'd1000;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] page_id;
        logic [47:0] now_ms;
        logic [31:0] paint_ms;
        logic        main_frame_current;
    } t_in;

    typedef struct packed {
        logic        expired_valid;
        logic [15:0] expired_page_id;
        logic        last;
        logic        status;
        logic        next_valid;
        logic [47:0] next_deadline_ms;
    } t_out;

    typedef enum logic [1:0] {
        SCAN_FIND   = 2'd0,
        SCAN_COUNT  = 2'd1,
        SCAN_SELECT = 2'd2
    } t_scan_kind;

    typedef struct packed {
        logic       capture;
        logic       scan_go;
        logic       scan_run;
        t_scan_kind kind;
        logic       apply;
        logic       emit_hit;
        logic       emit_none;
    } t_ctl_cmd;

    typedef struct packed {
        logic scan_done;
        logic cnt_zero;
        logic cnt_last;
        logic out_free;
    } t_ctl_sts;

endpackage

`default_nettype wire

// ----- hw/rtl/deadline_timeout_table_top.sv -----
// deadline timeout table, top level: controller plus datapath; uses dtt_pkg
// one item at a time; each slot scan reads one entry per cycle
// with no expiry the result is loaded after the find scan, the apply step and the count scan
// with n expired entries the k-th result is loaded after k select scans that follow the count scan
// next item is taken in the cycle after the last result is loaded; output stalls delay each result
// synchronous active-low reset clears valid bits, control and status flags and loads the config defaults
`timescale 1ns / 1ps
`default_nettype none

module deadline_timeout_table_top
    import dtt_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire t_in         i_data,
    output logic             o_valid,
    input  wire logic        i_stall,
    output t_out             o_data,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    t_ctl_cmd w_cmd;
    t_ctl_sts w_sts;

    dtt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    dtt_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_data      (i_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/dtt_ctrl.sv -----
// controller state machine for the deadline timeout table
// sequences lookup, update, expiry count and ordered expiry; uses dtt_pkg
`timescale 1ns / 1ps
`default_nettype none

module dtt_ctrl
    import dtt_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_stall,
    input  wire t_ctl_sts i_sts,
    output t_ctl_cmd      o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_FIND   = 7'b0000010,
        S_APPLY  = 7'b0000100,
        S_COUNT  = 7'b0001000,
        S_SELECT = 7'b0010000,
        S_EMIT   = 7'b0100000,
        S_NONE   = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.kind = SCAN_FIND;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    o_cmd.scan_go = 1'b1;
                    n_state = S_FIND;
                end
            end
            S_FIND: begin
                o_cmd.scan_run = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                o_cmd.apply   = 1'b1;
                o_cmd.scan_go = 1'b1;
                o_cmd.kind    = SCAN_COUNT;
                n_state = S_COUNT;
            end
            S_COUNT: begin
                o_cmd.scan_run = 1'b1;
                o_cmd.kind     = SCAN_COUNT;
                if (i_sts.scan_done) begin
                    if (i_sts.cnt_zero) begin
                        n_state = S_NONE;
                    end else begin
                        o_cmd.scan_go  = 1'b1;
                        o_cmd.scan_run = 1'b0;
                        o_cmd.kind     = SCAN_SELECT;
                        n_state = S_SELECT;
                    end
                end
            end
            S_SELECT: begin
                o_cmd.scan_run = 1'b1;
                o_cmd.kind     = SCAN_SELECT;
                if (i_sts.scan_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                o_cmd.kind = SCAN_SELECT;
                if (i_sts.out_free) begin
                    o_cmd.emit_hit = 1'b1;
                    if (i_sts.cnt_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.scan_go = 1'b1;
                        n_state = S_SELECT;
                    end
                end
            end
            S_NONE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_none = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/dtt_datapath.sv -----
// datapath for the deadline timeout table: entry memory, valid bits,
// slot scanner, deadline arithmetic and output register; uses dtt_pkg
`timescale 1ns / 1ps
`default_nettype none

module dtt_datapath
    import dtt_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_ctl_cmd    i_cmd,
    output t_ctl_sts         o_sts,
    input  wire t_in         i_data,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    output logic             o_valid,
    input  wire logic        i_stall,
    output t_out             o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] LAST_ADDR = CW'(DEPTH);

    typedef struct packed {
        logic [15:0] id;
        logic [47:0] deadline;
    } t_entry;

    function automatic logic [47:0] sat_add(input logic [47:0] a, input logic [31:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {17'b0, b};
        return s[48] ? 48'hFFFF_FFFF_FFFF : s[47:0];
    endfunction

    t_in             r_item;
    logic [31:0]     r_default;
    logic [31:0]     r_min_wait;
    logic [DEPTH-1:0] r_valid;
    t_entry          r_mem [DEPTH];
    t_entry          r_rd;
    logic [CW-1:0]   r_scan_addr;
    logic            r_scan_live;
    logic [AW-1:0]   r_scan_slot;
    logic            r_hit;
    logic [AW-1:0]   r_hit_slot;
    logic [47:0]     r_hit_dl;
    logic            r_free_ok;
    logic [AW-1:0]   r_free_slot;
    logic [CW-1:0]   r_cnt;
    logic            r_nv;
    logic [47:0]     r_ndl;
    logic            r_sel;
    logic [AW-1:0]   r_sel_slot;
    logic [47:0]     r_sel_dl;
    logic [15:0]     r_sel_id;
    logic            r_status;
    logic            r_out_valid;
    t_out            r_out;

    logic            w_v;
    logic            w_due;
    logic [31:0]     w_wait;
    logic [47:0]     w_when;
    logic [47:0]     w_def_dl;
    logic            w_ins_ok;
    logic [AW-1:0]   w_ins_slot;
    logic            w_upd;
    logic            w_we;
    logic [AW-1:0]   w_waddr;
    t_entry          w_wdata;
    logic            w_out_free;

    assign w_v   = r_valid[r_scan_slot];
    assign w_due = (r_rd.deadline <= r_item.now_ms);

    assign w_wait   = (r_item.paint_ms > r_min_wait) ? r_item.paint_ms : r_min_wait;
    assign w_when   = sat_add(r_item.now_ms, w_wait);
    assign w_def_dl = sat_add(r_item.now_ms, r_default);

    // lowest free slot once the old entry for the id is gone
    always_comb begin
        w_ins_ok   = r_hit || r_free_ok;
        w_ins_slot = r_free_slot;
        if (r_hit && (!r_free_ok || (r_hit_slot < r_free_slot))) begin
            w_ins_slot = r_hit_slot;
        end
    end

    assign w_upd = r_item.main_frame_current && r_hit && (w_when < r_hit_dl);

    always_comb begin
        w_we    = 1'b0;
        w_waddr = w_ins_slot;
        w_wdata.id       = r_item.page_id;
        w_wdata.deadline = w_def_dl;
        if (i_cmd.apply) begin
            if (r_item.mode == MODE_START) begin
                w_we = w_ins_ok;
            end else if (r_item.mode == MODE_PAINT) begin
                w_we    = w_upd;
                w_waddr = r_hit_slot;
                w_wdata.deadline = w_when;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (i_cmd.scan_run && (r_scan_addr < LAST_ADDR)) begin
            r_rd <= r_mem[r_scan_addr[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default  <= DEFAULT_TIMEOUT_RST;
            r_min_wait <= MIN_PAINT_WAIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DEFAULT_TIMEOUT: r_default  <= i_cfg_data;
                CFG_MIN_PAINT_WAIT:  r_min_wait <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (i_cmd.apply) begin
                if ((r_item.mode inside {MODE_START, MODE_REMOVE}) && r_hit) begin
                    r_valid[r_hit_slot] <= 1'b0;
                end
                if ((r_item.mode == MODE_START) && w_ins_ok) begin
                    r_valid[w_ins_slot] <= 1'b1;
                end
            end
            if (i_cmd.emit_hit) begin
                r_valid[r_sel_slot] <= 1'b0;
            end
        end
    end

    // slot scanner: one read issued per cycle, compared in the cycle after on the registered entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_addr <= LAST_ADDR;
            r_scan_live <= 1'b0;
        end else if (i_cmd.scan_go) begin
            r_scan_addr <= '0;
            r_scan_live <= 1'b0;
        end else if (i_cmd.scan_run) begin
            if (r_scan_addr < LAST_ADDR) begin
                r_scan_addr <= r_scan_addr + CW'(1);
                r_scan_live <= 1'b1;
            end else begin
                r_scan_live <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_run && (r_scan_addr < LAST_ADDR)) begin
            r_scan_slot <= r_scan_addr[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit     <= 1'b0;
            r_free_ok <= 1'b0;
            r_cnt     <= '0;
            r_nv      <= 1'b0;
            r_sel     <= 1'b0;
        end else if (i_cmd.scan_go) begin
            case (i_cmd.kind)
                SCAN_FIND: begin
                    r_hit     <= 1'b0;
                    r_free_ok <= 1'b0;
                end
                SCAN_COUNT: begin
                    r_cnt <= '0;
                    r_nv  <= 1'b0;
                end
                SCAN_SELECT: begin
                    r_sel <= 1'b0;
                end
                default: ;
            endcase
            if (i_cmd.emit_hit) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end else begin
            if (i_cmd.emit_hit) begin
                r_cnt <= r_cnt - CW'(1);
            end
            if (i_cmd.scan_run && r_scan_live) begin
                case (i_cmd.kind)
                    SCAN_FIND: begin
                        if (w_v && (r_rd.id == r_item.page_id)) begin
                            r_hit      <= 1'b1;
                            r_hit_slot <= r_scan_slot;
                            r_hit_dl   <= r_rd.deadline;
                        end
                        if (!w_v && !r_free_ok) begin
                            r_free_ok   <= 1'b1;
                            r_free_slot <= r_scan_slot;
                        end
                    end
                    SCAN_COUNT: begin
                        if (w_v && w_due) begin
                            r_cnt <= r_cnt + CW'(1);
                        end else if (w_v && (!r_nv || (r_rd.deadline < r_ndl))) begin
                            r_nv  <= 1'b1;
                            r_ndl <= r_rd.deadline;
                        end
                    end
                    SCAN_SELECT: begin
                        if (w_v && w_due && (!r_sel || (r_rd.deadline < r_sel_dl))) begin
                            r_sel      <= 1'b1;
                            r_sel_slot <= r_scan_slot;
                            r_sel_dl   <= r_rd.deadline;
                            r_sel_id   <= r_rd.id;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status <= 1'b0;
        end else if (i_cmd.capture) begin
            r_status <= 1'b0;
        end else if (i_cmd.apply && (r_item.mode == MODE_START) && !w_ins_ok) begin
            r_status <= 1'b1;
        end
    end

    assign w_out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_hit || i_cmd.emit_none) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_hit || i_cmd.emit_none) begin
            r_out.expired_valid    <= i_cmd.emit_hit;
            r_out.expired_page_id  <= i_cmd.emit_hit ? r_sel_id : 16'd0;
            r_out.last             <= i_cmd.emit_none || (r_cnt == CW'(1));
            r_out.status           <= r_status;
            r_out.next_valid       <= r_nv;
            r_out.next_deadline_ms <= r_nv ? r_ndl : 48'd0;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    assign o_sts.scan_done = (r_scan_addr == LAST_ADDR) && !r_scan_live;
    assign o_sts.cnt_zero  = (r_cnt == '0);
    assign o_sts.cnt_last  = (r_cnt == CW'(1));
    assign o_sts.out_free  = w_out_free;

endmodule

`default_nettype wire
